### hdl/pewc_pkg.sv
package pewc_pkg;

    // Event kinds carried in req_type
    localparam logic [1:0] REQ_RISE  = 2'd0;
    localparam logic [1:0] REQ_FALL  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    // Sequence id field inside the event id
    localparam int SEQ_LSB = 20;
    localparam int SEQ_W   = 12;
    localparam int SEQ_OUT_W = 4;

    localparam int TIME_W   = 64;
    localparam int COUNT_W  = 16;
    localparam int OFFSET_W = 31;
    localparam int WORD_W   = 32;

    // Configuration register indexes and bus shape
    localparam int PADDR_W = 3;
    localparam logic REG_LEVEL = 1'b0;

    localparam int DEF_NUM_SEQ_IDS = 16;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIME_W-1:0] event_id;
        logic [TIME_W-1:0] timestamp;
    } t_item;

    typedef struct packed {
        logic [SEQ_OUT_W-1:0] seq_id;
        logic [COUNT_W-1:0]   rising_count;
        logic [COUNT_W-1:0]   falling_count;
        logic [OFFSET_W-1:0]  rising_offset;
        logic [OFFSET_W-1:0]  falling_offset;
        logic                 rising_valid;
        logic                 falling_valid;
        logic signed [WORD_W-1:0] pulse_length;
        logic                 length_valid;
        logic [WORD_W-1:0]    level_word;
        logic [WORD_W-1:0]    publish_count;
    } t_rec;

endpackage

### hdl/pulse_edge_window_capture_top.sv
// Pulse edge window capture. Takes one event word per clock cycle: a start
// opens a measurement window, rising and falling edges inside it are counted
// and the first of each kind is timed against the start, and a stop closes
// the window and sends out one record word. Events whose sequence id (event
// id bits 31:20) is at or above NUM_SEQ_IDS, and edges or stops outside a
// window, are dropped. From input acceptance the word sits in the input
// register while the window logic (a 64-bit subtract and saturate) works on
// it, and the record is then loaded into the result register. Input stalls
// only when a stop sits in the input register behind a record that the
// consumer has not yet taken.
// Write comparator_level only while idle.
module pulse_edge_window_capture_top
    import pewc_pkg::*;
#(
    parameter int NUM_SEQ_IDS = DEF_NUM_SEQ_IDS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [WORD_W-1:0]        pwdata,
    output logic [WORD_W-1:0]        prdata,
    output logic                     pready,
    // event input
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_req_type,
    input  logic [TIME_W-1:0]        i_event_id,
    input  logic [TIME_W-1:0]        i_timestamp,
    // record output
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [SEQ_OUT_W-1:0]     o_seq_id,
    output logic [COUNT_W-1:0]       o_rising_count,
    output logic [COUNT_W-1:0]       o_falling_count,
    output logic [OFFSET_W-1:0]      o_rising_offset,
    output logic [OFFSET_W-1:0]      o_falling_offset,
    output logic                     o_rising_valid,
    output logic                     o_falling_valid,
    output logic signed [WORD_W-1:0] o_pulse_length,
    output logic                     o_length_valid,
    output logic [WORD_W-1:0]        o_level_word,
    output logic [WORD_W-1:0]        o_publish_count
);

    logic [WORD_W-1:0] level;
    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    t_rec              r_out;
    logic              emit;
    t_rec              rec;
    logic              out_free;
    logic              proc;
    logic              acc;

    pewc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_level (level)
    );

    pewc_win #(
        .NUM_SEQ_IDS (NUM_SEQ_IDS)
    ) u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_item  (r_in),
        .i_level (level),
        .o_emit  (emit),
        .o_rec   (rec)
    );

    // Handshake between the two register stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!emit || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign acc        = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_in.req_type  <= i_req_type;
            r_in.event_id  <= i_event_id;
            r_in.timestamp <= i_timestamp;
        end
    end

    // Result register: load a record, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out <= rec;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_seq_id         = r_out.seq_id;
    assign o_rising_count   = r_out.rising_count;
    assign o_falling_count  = r_out.falling_count;
    assign o_rising_offset  = r_out.rising_offset;
    assign o_falling_offset = r_out.falling_offset;
    assign o_rising_valid   = r_out.rising_valid;
    assign o_falling_valid  = r_out.falling_valid;
    assign o_pulse_length   = r_out.pulse_length;
    assign o_length_valid   = r_out.length_valid;
    assign o_level_word     = r_out.level_word;
    assign o_publish_count  = r_out.publish_count;

endmodule

### hdl/pewc_cfg.sv
module pewc_cfg
    import pewc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    output logic [WORD_W-1:0]  o_level
);

    logic              wr_level;
    logic [WORD_W-1:0] r_level;

    assign pready   = 1'b1;
    assign wr_level = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_LEVEL);

    // Hold the comparator level word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (wr_level) begin
            r_level <= pwdata;
        end
    end

    // Read back; addresses past the list read zero
    always_comb begin
        if (paddr[PADDR_W-1] == REG_LEVEL) begin
            prdata = r_level;
        end else begin
            prdata = '0;
        end
    end

    assign o_level = r_level;

endmodule

### hdl/pewc_win.sv
module pewc_win
    import pewc_pkg::*;
#(
    parameter int NUM_SEQ_IDS = DEF_NUM_SEQ_IDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_item             i_item,
    input  logic [WORD_W-1:0] i_level,
    output logic              o_emit,
    output t_rec              o_rec
);

    localparam logic [SEQ_W:0] SEQ_LIM = (SEQ_W+1)'(NUM_SEQ_IDS);

    logic                 r_armed;
    logic [TIME_W-1:0]    r_start;
    logic [SEQ_OUT_W-1:0] r_seq;
    logic [COUNT_W-1:0]   r_rcnt;
    logic [COUNT_W-1:0]   r_fcnt;
    logic [OFFSET_W-1:0]  r_roff;
    logic [OFFSET_W-1:0]  r_foff;
    logic [WORD_W-1:0]    r_pub;

    logic [SEQ_W-1:0]    seq;
    logic                in_range;
    logic                live;
    logic [TIME_W-1:0]   diff;
    logic [OFFSET_W-1:0] offset;
    logic                rv;
    logic                fv;

    assign seq      = i_item.event_id[SEQ_LSB +: SEQ_W];
    assign in_range = {1'b0, seq} < SEQ_LIM;
    assign live     = in_range && (r_armed || (i_item.req_type == REQ_START));

    // Offset from window start, saturated to 31 bits
    assign diff   = i_item.timestamp - r_start;
    assign offset = (|diff[TIME_W-1:OFFSET_W]) ? '1 : diff[OFFSET_W-1:0];

    assign o_emit = live && (i_item.req_type == REQ_STOP);

    // Advance window state on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_start <= '0;
            r_seq   <= '0;
            r_rcnt  <= '0;
            r_fcnt  <= '0;
            r_roff  <= '0;
            r_foff  <= '0;
            r_pub   <= '0;
        end else if (i_fire && live) begin
            case (i_item.req_type)
                REQ_START: begin
                    r_armed <= 1'b1;
                    r_start <= i_item.timestamp;
                    r_seq   <= seq[SEQ_OUT_W-1:0];
                    r_rcnt  <= '0;
                    r_fcnt  <= '0;
                    r_roff  <= '0;
                    r_foff  <= '0;
                end
                REQ_RISE: begin
                    if (r_rcnt == '0) begin
                        r_roff <= offset;
                    end
                    if (r_rcnt != '1) begin
                        r_rcnt <= r_rcnt + COUNT_W'(1);
                    end
                end
                REQ_FALL: begin
                    if (r_fcnt == '0) begin
                        r_foff <= offset;
                    end
                    if (r_fcnt != '1) begin
                        r_fcnt <= r_fcnt + COUNT_W'(1);
                    end
                end
                REQ_STOP: begin
                    r_armed <= 1'b0;
                    r_pub   <= r_pub + WORD_W'(1);
                end
                default: begin
                    r_armed <= r_armed;
                end
            endcase
        end
    end

    // Build the record for a stop
    assign rv = r_rcnt != '0;
    assign fv = r_fcnt != '0;

    always_comb begin
        o_rec.seq_id         = r_seq;
        o_rec.rising_count   = r_rcnt;
        o_rec.falling_count  = r_fcnt;
        o_rec.rising_offset  = rv ? r_roff : '0;
        o_rec.falling_offset = fv ? r_foff : '0;
        o_rec.rising_valid   = rv;
        o_rec.falling_valid  = fv;
        o_rec.length_valid   = rv && fv;
        o_rec.pulse_length   = (rv && fv) ?
            signed'({1'b0, r_foff} - {1'b0, r_roff}) : '0;
        o_rec.level_word     = i_level;
        o_rec.publish_count  = r_pub + WORD_W'(1);
    end

endmodule

### hdl/pewc_chk.sv
module pewc_chk
    import pewc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     o_out_valid,
    input  logic                     i_out_stall,
    input  logic [COUNT_W-1:0]       o_rising_count,
    input  logic [COUNT_W-1:0]       o_falling_count,
    input  logic [OFFSET_W-1:0]      o_rising_offset,
    input  logic [OFFSET_W-1:0]      o_falling_offset,
    input  logic                     o_rising_valid,
    input  logic                     o_falling_valid,
    input  logic signed [WORD_W-1:0] o_pulse_length,
    input  logic                     o_length_valid,
    input  logic [WORD_W-1:0]        o_publish_count
);

    logic              r_seen;
    logic [WORD_W-1:0] r_last;
    logic              out_acc;

    assign out_acc = o_out_valid && !i_out_stall;

    // Track the publish count of the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_acc) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_last <= o_publish_count;
        end
    end

    // A stalled record holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_publish_count))
        else $error("stalled record changed");

    // Records are numbered one after another
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen |-> o_publish_count == r_last + WORD_W'(1))
        else $error("publish count skipped or repeated");

    // Valid flags follow the counts
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rising_valid == (o_rising_count != '0)) &&
            (o_falling_valid == (o_falling_count != '0)) &&
            (o_length_valid == (o_rising_valid && o_falling_valid)))
        else $error("record flags disagree with counts");

    // Length is the difference of the offsets, zero otherwise
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pulse_length == (o_length_valid ?
            signed'({1'b0, o_falling_offset} - {1'b0, o_rising_offset}) : '0))
        else $error("pulse length wrong");

endmodule

bind pulse_edge_window_capture_top pewc_chk u_chk (.*);

### verif/pulse_edge_window_capture_top_test.sv
module pulse_edge_window_capture_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pewc_pkg::*;

    localparam int NUM_IDS      = DEF_NUM_SEQ_IDS;
    localparam int SETTLE       = 8;
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam logic [PADDR_W-1:0] LEVEL_ADDR = PADDR_W'({REG_LEVEL, 2'b00});

    // Receiver stall behaviour modes; the receiver picks a new one at random
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} t_rx_mode;

    // One line of the directed script: an event word and, where known, its record
    typedef struct {
        t_item ev;
        bit    typed;
        t_rec  rec;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [WORD_W-1:0]        pwdata = '0;
    logic [WORD_W-1:0]        prdata;
    logic                     pready;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_req_type = REQ_RISE;
    logic [TIME_W-1:0]        i_event_id = '0;
    logic [TIME_W-1:0]        i_timestamp = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [SEQ_OUT_W-1:0]     o_seq_id;
    logic [COUNT_W-1:0]       o_rising_count;
    logic [COUNT_W-1:0]       o_falling_count;
    logic [OFFSET_W-1:0]      o_rising_offset;
    logic [OFFSET_W-1:0]      o_falling_offset;
    logic                     o_rising_valid;
    logic                     o_falling_valid;
    logic signed [WORD_W-1:0] o_pulse_length;
    logic                     o_length_valid;
    logic [WORD_W-1:0]        o_level_word;
    logic [WORD_W-1:0]        o_publish_count;

    // Shadow of the window state
    logic                win_armed = 1'b0;
    logic [TIME_W-1:0]   win_start = '0;
    logic [3:0]          win_seq = '0;
    logic [COUNT_W-1:0]  rise_cnt = '0;
    logic [COUNT_W-1:0]  fall_cnt = '0;
    logic [OFFSET_W-1:0] rise_off = '0;
    logic [OFFSET_W-1:0] fall_off = '0;
    logic [WORD_W-1:0]   rec_total = '0;
    logic [WORD_W-1:0]   level_shadow = '0;

    t_rec owed_records[$];
    t_row script[$];

    int mismatches = 0;
    int n_words = 0;
    int n_acted = 0;
    int n_records = 0;
    int n_levels = 0;
    int burst_left = 0;
    int cycle_cnt = 0;
    t_rx_mode rx_mode = RX_FREE;
    int rx_left = 0;

    pulse_edge_window_capture_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_event_id       (i_event_id),
        .i_timestamp      (i_timestamp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_seq_id         (o_seq_id),
        .o_rising_count   (o_rising_count),
        .o_falling_count  (o_falling_count),
        .o_rising_offset  (o_rising_offset),
        .o_falling_offset (o_falling_offset),
        .o_rising_valid   (o_rising_valid),
        .o_falling_valid  (o_falling_valid),
        .o_pulse_length   (o_pulse_length),
        .o_length_valid   (o_length_valid),
        .o_level_word     (o_level_word),
        .o_publish_count  (o_publish_count)
    );

    // Run the clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [TIME_W-1:0] id_for(int seq);
        logic [11:0] s;
        s = 12'(seq);
        return {32'h0, s, 20'h0};
    endfunction

    // Event id with the given sequence id and every other bit random
    function automatic logic [TIME_W-1:0] rand_id(int seq);
        logic [11:0] s;
        logic [19:0] lo;
        s  = 12'(seq);
        lo = 20'($urandom);
        return {32'($urandom), s, lo};
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 1000));
            1: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic t_row row(logic [1:0] k, logic [TIME_W-1:0] id,
                                 logic [TIME_W-1:0] ts);
        t_row r;
        r.ev.req_type  = k;
        r.ev.event_id  = id;
        r.ev.timestamp = ts;
        r.typed = 1'b0;
        r.rec   = '0;
        return r;
    endfunction

    function automatic t_rec rec_of(logic [3:0] seq, logic [15:0] rc, logic [15:0] fc,
                                    logic [30:0] ro, logic [30:0] fo, logic rv, logic fv,
                                    logic [31:0] len, logic lv, logic [31:0] lvl,
                                    logic [31:0] pub);
        t_rec r;
        r.seq_id         = seq;
        r.rising_count   = rc;
        r.falling_count  = fc;
        r.rising_offset  = ro;
        r.falling_offset = fo;
        r.rising_valid   = rv;
        r.falling_valid  = fv;
        r.pulse_length   = len;
        r.length_valid   = lv;
        r.level_word     = lvl;
        r.publish_count  = pub;
        return r;
    endfunction

    function automatic t_row row_rec(logic [1:0] k, logic [TIME_W-1:0] id,
                                     logic [TIME_W-1:0] ts, t_rec rec);
        t_row r;
        r = row(k, id, ts);
        r.typed = 1'b1;
        r.rec   = rec;
        return r;
    endfunction

    // Offset of an edge from the window start, saturated to 31 bits
    function automatic logic [OFFSET_W-1:0] edge_offset(logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] d;
        d = t - win_start;
        if (d > 64'h7FFF_FFFF)
            return '1;
        return d[OFFSET_W-1:0];
    endfunction

    function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Advance the window shadow by one event word; hand back a record on a stop
    task automatic track_window(input t_item ev, output bit acted, output bit closed,
                                output t_rec rec);
        logic [11:0] sid;
        logic rv, fv, lv;
        sid    = ev.event_id[SEQ_LSB +: SEQ_W];
        acted  = 1'b0;
        closed = 1'b0;
        rec    = '0;
        if (int'(sid) >= NUM_IDS)
            return;
        if (!win_armed && ev.req_type != REQ_START)
            return;
        acted = 1'b1;
        case (ev.req_type)
            REQ_START: begin
                win_seq   = sid[3:0];
                win_start = ev.timestamp;
                win_armed = 1'b1;
                rise_cnt  = '0;
                fall_cnt  = '0;
                rise_off  = '0;
                fall_off  = '0;
            end
            REQ_RISE: begin
                if (rise_cnt == 0)
                    rise_off = edge_offset(ev.timestamp);
                if (rise_cnt != '1)
                    rise_cnt++;
            end
            REQ_FALL: begin
                if (fall_cnt == 0)
                    fall_off = edge_offset(ev.timestamp);
                if (fall_cnt != '1)
                    fall_cnt++;
            end
            REQ_STOP: begin
                win_armed = 1'b0;
                rec_total++;
                rv = rise_cnt != 0;
                fv = fall_cnt != 0;
                lv = rv && fv;
                rec.seq_id         = win_seq;
                rec.rising_count   = rise_cnt;
                rec.falling_count  = fall_cnt;
                rec.rising_offset  = rv ? rise_off : '0;
                rec.falling_offset = fv ? fall_off : '0;
                rec.rising_valid   = rv;
                rec.falling_valid  = fv;
                rec.pulse_length   = lv ? ({1'b0, fall_off} - {1'b0, rise_off}) : '0;
                rec.length_valid   = lv;
                rec.level_word     = level_shadow;
                rec.publish_count  = rec_total;
                closed = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Offer one word in the current burst, or open a new burst after a gap
    task automatic send_word(input t_item ev);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= ev.req_type;
        i_event_id  <= ev.event_id;
        i_timestamp <= ev.timestamp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    // Send a word and queue the record it owes, typed or worked out
    task automatic apply_word(input t_item ev, input bit typed, input t_rec trec,
                              output bit acted);
        bit closed;
        t_rec rec;
        send_word(ev);
        track_window(ev, acted, closed, rec);
        n_words++;
        if (acted)
            n_acted++;
        if (closed)
            owed_records.push_back(typed ? trec : rec);
    endtask

    task automatic send_event(input logic [1:0] k, input logic [TIME_W-1:0] id,
                              input logic [TIME_W-1:0] ts, output bit acted);
        t_row r;
        r = row(k, id, ts);
        apply_word(r.ev, 1'b0, r.rec, acted);
    endtask

    // Drop valid and let the block drain before touching the register
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (owed_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the level register, then read it back
    task automatic set_level(input logic [WORD_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEVEL_ADDR;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        level_shadow = v;
        n_levels++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== v) begin
            $display("%0t: level read back mismatch, expected %h, got %h", $time, v, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed windows with random content, the rest noise
    task automatic run_windows(input int target);
        int done, n, j;
        bit acted;
        logic [TIME_W-1:0] base, ts, id;
        logic [1:0] k;
        done = 0;
        while (done < target) begin
            if ($urandom_range(0, 9) < 8) begin
                base = pick_time();
                send_event(REQ_START, rand_id($urandom_range(0, NUM_IDS - 1)), base, acted);
                done += acted;
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        base = pick_time();
                        k = REQ_START;
                    end else begin
                        k = $urandom_range(0, 1) ? REQ_RISE : REQ_FALL;
                    end
                    case ($urandom_range(0, 7))
                        5: ts = base + {32'h0, 32'($urandom)};
                        6: ts = base - 64'($urandom_range(1, 100));
                        7: ts = {32'($urandom), 32'($urandom)};
                        default: ts = base + 64'($urandom_range(0, 5000));
                    endcase
                    id = ($urandom_range(0, 9) == 0) ? rand_id($urandom_range(NUM_IDS, 4095))
                                                     : rand_id($urandom_range(0, NUM_IDS - 1));
                    send_event(k, id, ts, acted);
                    done += acted;
                end
                // leave the odd window open so the next start abandons it
                if ($urandom_range(0, 14) != 0) begin
                    send_event(REQ_STOP, rand_id($urandom_range(0, NUM_IDS - 1)),
                               {32'($urandom), 32'($urandom)}, acted);
                    done += acted;
                end
            end else begin
                n = $urandom_range(1, 4);
                for (j = 0; j < n; j++) begin
                    send_event(2'($urandom), {32'($urandom), 32'($urandom)},
                               {32'($urandom), 32'($urandom)}, acted);
                    done += acted;
                end
            end
        end
    endtask

    // Take records and check them; stall on a pattern of changing modes
    always @(posedge i_clk) begin
        t_rec got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.seq_id         = o_seq_id;
            got.rising_count   = o_rising_count;
            got.falling_count  = o_falling_count;
            got.rising_offset  = o_rising_offset;
            got.falling_offset = o_falling_offset;
            got.rising_valid   = o_rising_valid;
            got.falling_valid  = o_falling_valid;
            got.pulse_length   = o_pulse_length;
            got.length_valid   = o_length_valid;
            got.level_word     = o_level_word;
            got.publish_count  = o_publish_count;
            if (owed_records.size() == 0) begin
                $display("%0t: record word with none expected, publish_count %h",
                         $time, got.publish_count);
                mismatches++;
            end else begin
                want = owed_records.pop_front();
                n_records++;
                mismatches += field_bad("seq_id", 64'(want.seq_id), 64'(got.seq_id));
                mismatches += field_bad("rising_count", 64'(want.rising_count),
                                        64'(got.rising_count));
                mismatches += field_bad("falling_count", 64'(want.falling_count),
                                        64'(got.falling_count));
                mismatches += field_bad("rising_offset", 64'(want.rising_offset),
                                        64'(got.rising_offset));
                mismatches += field_bad("falling_offset", 64'(want.falling_offset),
                                        64'(got.falling_offset));
                mismatches += field_bad("rising_valid", 64'(want.rising_valid),
                                        64'(got.rising_valid));
                mismatches += field_bad("falling_valid", 64'(want.falling_valid),
                                        64'(got.falling_valid));
                mismatches += field_bad("pulse_length", 64'(want.pulse_length),
                                        64'(got.pulse_length));
                mismatches += field_bad("length_valid", 64'(want.length_valid),
                                        64'(got.length_valid));
                mismatches += field_bad("level_word", 64'(want.level_word),
                                        64'(got.level_word));
                mismatches += field_bad("publish_count", 64'(want.publish_count),
                                        64'(got.publish_count));
            end
        end
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:  i_out_stall <= (rx_left > 10);
        endcase
    end

    initial begin
        bit acted;
        logic [31:0] lvl;

        lvl = 32'hFFFF_FFFF;
        // Directed script: idle drops, out-of-range ids, offsets at and past
        // the 31-bit limit, edges before the start, restart while armed,
        // negative pulse length
        script.push_back(row(REQ_STOP, id_for(0), 64'd0));
        script.push_back(row(REQ_RISE, id_for(0), 64'd5));
        script.push_back(row(REQ_START, id_for(15), 64'd1000));
        script.push_back(row_rec(REQ_STOP, id_for(15), 64'd2000,
            rec_of(4'd15, 16'd0, 16'd0, 31'd0, 31'd0, 1'b0, 1'b0, 32'd0, 1'b0, lvl, 32'd1)));
        script.push_back(row(REQ_START, id_for(NUM_IDS), 64'd10));
        script.push_back(row(REQ_START, 64'hFFFF_FFFF_FFFF_FFFF, 64'd20));
        script.push_back(row(REQ_START, 64'hFFFF_FFFF_000F_FFFF, 64'd100));
        script.push_back(row(REQ_RISE, id_for(7), 64'd100));
        script.push_back(row(REQ_FALL, id_for(0), 64'd50));
        script.push_back(row(REQ_RISE, id_for(2), 64'd1_000_000));
        script.push_back(row(REQ_RISE, 64'h0000_0000_FFF0_0000, 64'd200));
        script.push_back(row_rec(REQ_STOP, id_for(0), 64'd0,
            rec_of(4'd0, 16'd2, 16'd1, 31'd0, 31'h7FFF_FFFF, 1'b1, 1'b1,
                   32'h7FFF_FFFF, 1'b1, lvl, 32'd2)));
        script.push_back(row(REQ_START, id_for(5), 64'd0));
        script.push_back(row(REQ_FALL, id_for(5), 64'h7FFF_FFFF));
        script.push_back(row(REQ_RISE, id_for(5), 64'h8000_0000));
        script.push_back(row(REQ_START, id_for(9), 64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(row(REQ_RISE, id_for(9), 64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(row(REQ_FALL, id_for(9), 64'd0));
        script.push_back(row_rec(REQ_STOP, id_for(9), 64'd3,
            rec_of(4'd9, 16'd1, 16'd1, 31'd0, 31'd1, 1'b1, 1'b1, 32'd1, 1'b1, lvl, 32'd3)));
        script.push_back(row(REQ_START, id_for(3), 64'd10));
        script.push_back(row(REQ_RISE, id_for(3), 64'd30));
        script.push_back(row(REQ_FALL, id_for(3), 64'd20));
        script.push_back(row(REQ_FALL, id_for(3), 64'd25));
        script.push_back(row_rec(REQ_STOP, id_for(3), 64'd40,
            rec_of(4'd3, 16'd1, 16'd2, 31'd20, 31'd10, 1'b1, 1'b1,
                   32'hFFFF_FFF6, 1'b1, lvl, 32'd4)));
        script.push_back(row(REQ_STOP, id_for(3), 64'd50));

        // Hold reset, then release it
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        set_level(lvl);
        foreach (script[r])
            apply_word(script[r].ev, script[r].typed, script[r].rec, acted);
        drain();

        // Random windows under several level settings
        set_level($urandom);
        run_windows(180);
        drain();
        set_level(32'h7FFF_FFFF);
        run_windows(180);
        drain();
        set_level($urandom);
        run_windows(180);
        drain();
        set_level(32'hFFFF_FFFF);
        run_windows(180);
        drain();

        if (owed_records.size() != 0)
            mismatches++;
        $display("Sent %0d event words (%0d acted on), checked %0d records,",
                 n_words, n_acted, n_records);
        $display("level register set %0d times, %0d mismatches", n_levels, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### pulse_edge_window_capture_top.f
hdl/pewc_pkg.sv
hdl/pewc_cfg.sv
hdl/pewc_win.sv
hdl/pulse_edge_window_capture_top.sv
hdl/pewc_chk.sv
verif/pulse_edge_window_capture_top_test.sv
